// ----- sv/wsfp_pkg.sv -----
// shared types and constants for the websocket frame parser
`default_nettype none

package wsfp_pkg;

    localparam logic [2:0] KIND_DATA       = 3'd0;
    localparam logic [2:0] KIND_MSG_END    = 3'd1;
    localparam logic [2:0] KIND_PONG_BYTE  = 3'd2;
    localparam logic [2:0] KIND_PONG_EMPTY = 3'd3;
    localparam logic [2:0] KIND_CLOSE      = 3'd4;
    localparam logic [2:0] KIND_BAD_LEN    = 3'd5;

    localparam logic [3:0] OP_CONT = 4'h0;
    localparam logic [3:0] OP_TEXT = 4'h1;
    localparam logic [3:0] OP_BIN  = 4'h2;
    localparam logic [3:0] OP_PING = 4'h9;
    localparam logic [3:0] OP_PONG = 4'hA;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       msg_end;
        logic       last;
    } wsfp_res_t;

endpackage

`default_nettype wire

// ----- sv/wsfp_in_stage.sv -----
// input register for received bytes
`default_nettype none

module wsfp_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       process,
    output logic            in_valid,
    output logic [7:0]      in_byte
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       take;

    assign s_tready = !in_valid_reg || process;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (process) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_byte_reg <= s_tdata;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_byte  = in_byte_reg;

endmodule

`default_nettype wire

// ----- sv/wsfp_core.sv -----
// frame header walker, payload unmasking and result selection
`default_nettype none

module wsfp_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          process,
    input  wire logic [7:0]    in_byte,
    output logic               res_valid,
    output wsfp_pkg::wsfp_res_t res
);

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_PAY  = 3'd4;

    logic [2:0]  phase_reg,   phase_next;
    logic [3:0]  opcode_reg,  opcode_next;
    logic        fin_reg,     fin_next;
    logic        masked_reg,  masked_next;
    logic [3:0]  hbl_reg,     hbl_next;
    logic [31:0] key_reg,     key_next;
    logic [63:0] pl_reg,      pl_next;
    logic [1:0]  idx_reg,     idx_next;
    logic        closing_reg, closing_next;
    logic        bad_reg,     bad_next;

    logic        is_data;
    logic        len_end;
    logic        len_masked;
    logic        key_end;
    logic        hdr_zero;
    logic        hdr_end;
    logic [63:0] pl_shift;
    logic [63:0] pl_dec;
    logic [7:0]  key_byte;
    logic        pay_last;

    assign is_data = (opcode_reg == wsfp_pkg::OP_CONT) || (opcode_reg == wsfp_pkg::OP_TEXT)
                  || (opcode_reg == wsfp_pkg::OP_BIN);
    assign pl_shift = {pl_reg[55:0], in_byte};
    assign pl_dec   = pl_reg - 64'd1;
    assign pay_last = (pl_dec == 64'd0);

    always_comb begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        fin_next     = fin_reg;
        masked_next  = masked_reg;
        hbl_next     = hbl_reg;
        key_next     = key_reg;
        pl_next      = pl_reg;
        idx_next     = idx_reg;
        closing_next = closing_reg;
        bad_next     = bad_reg;
        res_valid    = 1'b0;
        res          = '0;
        len_end      = 1'b0;
        len_masked   = masked_reg;
        key_end      = 1'b0;
        hdr_zero     = 1'b0;

        if (!bad_reg) begin
            case (phase_reg)
                PH_HDR0: begin
                    fin_next    = in_byte[7];
                    opcode_next = in_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1: begin
                    masked_next = in_byte[7];
                    len_masked  = in_byte[7];
                    key_next    = '0;
                    idx_next    = '0;
                    if (in_byte[6:0] < wsfp_pkg::LEN_EXT16) begin
                        pl_next  = {57'd0, in_byte[6:0]};
                        hbl_next = 4'd0;
                        len_end  = 1'b1;
                        hdr_zero = (in_byte[6:0] == 7'd0);
                    end else begin
                        pl_next    = '0;
                        hbl_next   = (in_byte[6:0] == wsfp_pkg::LEN_EXT64) ? 4'd8 : 4'd2;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    pl_next  = pl_shift;
                    hbl_next = 4'(hbl_reg - 4'd1);
                    if (hbl_next == 4'd0) begin
                        if (pl_shift[63]) begin
                            bad_next     = 1'b1;
                            closing_next = 1'b1;
                            phase_next   = PH_HDR0;
                            res_valid    = 1'b1;
                            res.kind     = wsfp_pkg::KIND_BAD_LEN;
                            res.last     = 1'b1;
                        end else begin
                            len_end  = 1'b1;
                            hdr_zero = (pl_shift == 64'd0);
                        end
                    end
                end
                PH_KEY: begin
                    key_next = {key_reg[23:0], in_byte};
                    hbl_next = 4'(hbl_reg - 4'd1);
                    if (hbl_next == 4'd0) begin
                        key_end  = 1'b1;
                        hdr_zero = (pl_reg == 64'd0);
                    end
                end
                PH_PAY: begin
                    idx_next = 2'(idx_reg + 2'd1);
                    pl_next  = pl_dec;
                    if (pay_last) begin
                        phase_next = PH_HDR0;
                    end
                    if (is_data) begin
                        res_valid   = 1'b1;
                        res.kind    = wsfp_pkg::KIND_DATA;
                        res.data    = in_byte ^ key_byte;
                        res.msg_end = pay_last && fin_reg;
                        res.last    = pay_last;
                    end else if (opcode_reg == wsfp_pkg::OP_PING) begin
                        if (!closing_reg) begin
                            res_valid = 1'b1;
                            res.kind  = wsfp_pkg::KIND_PONG_BYTE;
                            res.data  = in_byte ^ key_byte;
                            res.last  = pay_last;
                        end
                    end else if (opcode_reg != wsfp_pkg::OP_PONG && pay_last) begin
                        if (!closing_reg) begin
                            closing_next = 1'b1;
                            res_valid    = 1'b1;
                            res.kind     = wsfp_pkg::KIND_CLOSE;
                            res.last     = 1'b1;
                        end
                    end
                end
                default: begin
                    phase_next = PH_HDR0;
                end
            endcase

            if (len_end && len_masked) begin
                hbl_next   = 4'd4;
                phase_next = PH_KEY;
            end

            hdr_end = (len_end && !len_masked) || key_end;
            if (hdr_end) begin
                if (!hdr_zero) begin
                    phase_next = PH_PAY;
                end else begin
                    phase_next = PH_HDR0;
                    if (is_data) begin
                        if (fin_reg) begin
                            res_valid   = 1'b1;
                            res.kind    = wsfp_pkg::KIND_MSG_END;
                            res.msg_end = 1'b1;
                            res.last    = 1'b1;
                        end
                    end else if (opcode_reg == wsfp_pkg::OP_PING) begin
                        if (!closing_reg) begin
                            res_valid = 1'b1;
                            res.kind  = wsfp_pkg::KIND_PONG_EMPTY;
                            res.last  = 1'b1;
                        end
                    end else if (opcode_reg != wsfp_pkg::OP_PONG) begin
                        if (!closing_reg) begin
                            closing_next = 1'b1;
                            res_valid    = 1'b1;
                            res.kind     = wsfp_pkg::KIND_CLOSE;
                            res.last     = 1'b1;
                        end
                    end
                end
            end
        end else begin
            hdr_end = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR0;
            opcode_reg  <= '0;
            fin_reg     <= 1'b0;
            masked_reg  <= 1'b0;
            hbl_reg     <= '0;
            key_reg     <= '0;
            pl_reg      <= '0;
            idx_reg     <= '0;
            closing_reg <= 1'b0;
            bad_reg     <= 1'b0;
        end else if (process) begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            fin_reg     <= fin_next;
            masked_reg  <= masked_next;
            hbl_reg     <= hbl_next;
            key_reg     <= key_next;
            pl_reg      <= pl_next;
            idx_reg     <= idx_next;
            closing_reg <= closing_next;
            bad_reg     <= bad_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/wsfp_out_stage.sv -----
// result register towards the master side
`default_nettype none

module wsfp_out_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire wsfp_pkg::wsfp_res_t res,
    output logic                     out_free,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,
    output logic [3:0]               m_tuser,
    output logic                     m_tlast
);

    logic                out_valid_reg;
    logic                out_valid_next;
    wsfp_pkg::wsfp_res_t out_res_reg;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.data;
    assign m_tuser  = {out_res_reg.msg_end, out_res_reg.kind};
    assign m_tlast  = out_res_reg.last;

endmodule

`default_nettype wire

// ----- sv/websocket_frame_parser_unit.sv -----
// top level of the websocket receive frame parser
// a byte waits in the input register until it is processed, and its result is then registered in the output stage
// throughput: one byte per cycle while results are not held up by m_tready, at most one result per byte
// the next byte is taken while a finished result waits on m_tready only if the held byte yields no result
// reset: synchronous active-low aresetn returns the parser to the first header byte
// a bad length stops all output until the next reset
`default_nettype none

module websocket_frame_parser_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic [3:0]      m_tuser,   // out_kind[2:0], msg_end[3]
    output logic            m_tlast    // frame_last
);

    logic                in_valid;
    logic [7:0]          in_byte;
    logic                process;
    logic                res_valid;
    logic                out_free;
    wsfp_pkg::wsfp_res_t res;

    assign process = in_valid && (out_free || !res_valid);

    wsfp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .process  (process),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    wsfp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .process   (process),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (process && res_valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- sv/wsfp_checker.sv -----
// port-level checks for the websocket frame parser and their binding
`default_nettype none

module wsfp_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [3:0] m_tuser,
    input wire logic       m_tlast
);

    logic [2:0] kind;
    logic       msg_end;

    assign kind    = m_tuser[2:0];
    assign msg_end = m_tuser[3];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && kind != wsfp_pkg::KIND_DATA && kind != wsfp_pkg::KIND_PONG_BYTE
            |-> m_tdata == 8'd0)
        else $error("non-byte item carries data");

    a_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (kind == wsfp_pkg::KIND_MSG_END || kind == wsfp_pkg::KIND_PONG_EMPTY
            || kind == wsfp_pkg::KIND_CLOSE || kind == wsfp_pkg::KIND_BAD_LEN)
            |-> m_tlast)
        else $error("frame-ending item without tlast");

    a_msg_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && msg_end |-> m_tlast
            && (kind == wsfp_pkg::KIND_DATA || kind == wsfp_pkg::KIND_MSG_END))
        else $error("message end on wrong item");

    a_no_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && kind == wsfp_pkg::KIND_MSG_END |-> msg_end)
        else $error("empty message end without flag");

endmodule

bind websocket_frame_parser_unit wsfp_checker u_wsfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
